@@ design/btc_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and cell-chain structs for the transitive closure block
// no dependencies
package btc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = 4;
  localparam int SIZE_W       = 5;
  localparam int WORD_W       = 64;
  localparam int CMD_W        = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  // word handed from one cell to the next
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  j;
    logic [WORD_W-1:0] word;
  } tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  k;
    logic [SIZE_W-1:0] size;
    logic              piv_cap;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_row;
    logic [IDX_W-1:0]  wr_col;
    logic [WORD_W-1:0] wr_data;
  } ctl_t;

endpackage

@@ design/btc_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for input and result words
// depends on btc_pkg
interface btc_in_if;
  logic                      valid;
  logic                      ready;
  logic [btc_pkg::CMD_W-1:0]  cmd;
  logic [btc_pkg::IDX_W-1:0]  row_index;
  logic [btc_pkg::IDX_W-1:0]  col_index;
  logic [btc_pkg::WORD_W-1:0] entry_word;
  modport source (output valid, cmd, row_index, col_index, entry_word, input ready);
  modport sink   (input valid, cmd, row_index, col_index, entry_word, output ready);
endinterface

interface btc_out_if;
  logic                      valid;
  logic                      ready;
  logic [btc_pkg::WORD_W-1:0] result_word;
  logic                      reachable;
  logic                      index_error;
  modport source (output valid, result_word, reachable, index_error, input ready);
  modport sink   (input valid, result_word, reachable, index_error, output ready);
endinterface

@@ design/btc_cell.sv @@
`timescale 1ns / 1ps
// one matrix row: row memory, pivot word and a one-stage update of the passing word
// depends on btc_pkg
module btc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [btc_pkg::IDX_W-1:0]  cell_id,
  input  btc_pkg::ctl_t              ctl,
  input  btc_pkg::tok_t              tok_in,
  output btc_pkg::tok_t              tok_out,
  output logic [btc_pkg::WORD_W-1:0] rd_q
);

  logic [btc_pkg::WORD_W-1:0] mem [btc_pkg::MAX_VERTICES];
  logic [btc_pkg::WORD_W-1:0] rd_q_r;
  logic [btc_pkg::WORD_W-1:0] piv_r;
  btc_pkg::tok_t              tok_r;
  logic                       is_src;
  logic                       use_tok;
  logic                       in_range;
  logic [btc_pkg::IDX_W-1:0]  rd_addr;

  // the pivot row only feeds the chain, its own update is a no-op
  assign is_src   = (cell_id == ctl.k);
  assign use_tok  = tok_in.valid && !is_src;
  assign in_range = ({1'b0, cell_id} < ctl.size);
  assign rd_addr  = use_tok ? tok_in.j : ctl.rd_addr;

  // registered row read
  always_ff @(posedge clk) begin
    rd_q_r <= mem[rd_addr];
  end

  // row write: command write or chain update
  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_row == cell_id) begin
      mem[ctl.wr_col] <= ctl.wr_data;
    end else if (tok_r.valid && !is_src && in_range) begin
      mem[tok_r.j] <= rd_q_r | (piv_r & tok_r.word);
    end
  end

  // pivot column word for this pass
  always_ff @(posedge clk) begin
    if (ctl.piv_cap) begin
      piv_r <= rd_q_r;
    end
  end

  // hand the word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
    end
    tok_r.j    <= tok_in.j;
    tok_r.word <= tok_in.word;
  end

  assign tok_out = tok_r;
  assign rd_q    = rd_q_r;

endmodule

@@ design/boolean_transitive_closure.sv @@
`timescale 1ns / 1ps
// top level: command sequencer, result register and the chain of row cells
// depends on btc_pkg, btc_if and btc_cell
//
// Boolean transitive closure over a 16x16 matrix of 64-bit words, one row per
// cell in a chain. A write or an out-of-range item sets the result register
// straight from idle, a read goes through the read state; for each pivot of a
// compute, the pivot row word streams down the cell chain and drains through
// all cells before the next pivot. One item is in work at a time; a new word is
// taken once the result register is empty.
module boolean_transitive_closure (
  input  logic                          clk,
  input  logic                          rst_n,
  btc_in_if.sink                        in_ch,
  btc_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [btc_pkg::SIZE_W-1:0]    cfg_wr_data
);

  localparam int DRN_LEN = btc_pkg::MAX_VERTICES + 2;
  localparam int DRN_W   = $clog2(DRN_LEN + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_PIV  = 3'd2;
  localparam logic [2:0] ST_CAP  = 3'd3;
  localparam logic [2:0] ST_SRC  = 3'd4;
  localparam logic [2:0] ST_DRN  = 3'd5;
  localparam logic [2:0] ST_QRY  = 3'd6;

  logic [2:0]                 state_r;
  logic [btc_pkg::SIZE_W-1:0] size_r;
  logic [btc_pkg::SIZE_W-1:0] eff;
  logic [btc_pkg::SIZE_W-1:0] k_r;
  logic [btc_pkg::IDX_W-1:0]  j_r;
  logic [DRN_W-1:0]           drn_r;
  logic [btc_pkg::IDX_W-1:0]  row_r;
  logic [btc_pkg::IDX_W-1:0]  col_r;
  logic                       cmp_r;
  logic                       src_v_r;
  logic [btc_pkg::IDX_W-1:0]  src_j_r;
  logic                       out_valid_r;
  logic [btc_pkg::WORD_W-1:0] out_word_r;
  logic                       out_reach_r;
  logic                       out_err_r;
  logic                       accept;
  logic                       idx_err;
  logic [btc_pkg::SIZE_W-1:0] k_nxt;
  btc_pkg::ctl_t              ctl;
  btc_pkg::tok_t              tok [btc_pkg::MAX_VERTICES+1];
  logic [btc_pkg::WORD_W-1:0] rd_q [btc_pkg::MAX_VERTICES];
  logic [btc_pkg::WORD_W-1:0] rd_word;

  // effective size, clamped to 1..MAX_VERTICES
  always_comb begin
    eff = size_r;
    if (size_r == '0) begin
      eff = btc_pkg::SIZE_W'(1);
    end else if (size_r > btc_pkg::SIZE_W'(btc_pkg::MAX_VERTICES)) begin
      eff = btc_pkg::SIZE_W'(btc_pkg::MAX_VERTICES);
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_err     = ({1'b0, in_ch.row_index} >= eff) || ({1'b0, in_ch.col_index} >= eff);
  assign k_nxt       = k_r + btc_pkg::SIZE_W'(1);

  // broadcast control
  always_comb begin
    ctl.k       = k_r[btc_pkg::IDX_W-1:0];
    ctl.size    = eff;
    ctl.piv_cap = (state_r == ST_CAP);
    ctl.wr_en   = accept && !idx_err && (in_ch.cmd == btc_pkg::CMD_WRITE);
    ctl.wr_row  = in_ch.row_index;
    ctl.wr_col  = in_ch.col_index;
    ctl.wr_data = in_ch.entry_word;
    case (state_r)
      ST_IDLE: ctl.rd_addr = in_ch.col_index;
      ST_PIV:  ctl.rd_addr = k_r[btc_pkg::IDX_W-1:0];
      ST_SRC:  ctl.rd_addr = j_r;
      default: ctl.rd_addr = col_r;
    endcase
  end

  // pivot row word enters the head of the chain
  assign tok[0].valid = src_v_r;
  assign tok[0].j     = src_j_r;
  assign tok[0].word  = rd_q[k_r[btc_pkg::IDX_W-1:0]];
  assign rd_word      = rd_q[row_r];

  genvar gi;
  generate
    for (gi = 0; gi < btc_pkg::MAX_VERTICES; gi++) begin : g_cell
      btc_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_id (btc_pkg::IDX_W'(gi)),
        .ctl     (ctl),
        .tok_in  (tok[gi]),
        .tok_out (tok[gi+1]),
        .rd_q    (rd_q[gi])
      );
    end
  endgenerate

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= btc_pkg::SIZE_W'(btc_pkg::MAX_VERTICES);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      src_v_r     <= 1'b0;
    end else begin
      src_v_r <= (state_r == ST_SRC);
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept && in_ch.cmd != btc_pkg::CMD_NONE) begin
            if (idx_err || in_ch.cmd == btc_pkg::CMD_WRITE) begin
              out_valid_r <= 1'b1;
            end else if (in_ch.cmd == btc_pkg::CMD_READ) begin
              state_r <= ST_RD;
            end else begin
              state_r <= ST_PIV;
            end
          end
        end
        ST_RD: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        ST_PIV: state_r <= ST_CAP;
        ST_CAP: state_r <= ST_SRC;
        ST_SRC: begin
          if ({1'b0, j_r} == eff - btc_pkg::SIZE_W'(1)) begin
            state_r <= ST_DRN;
          end
        end
        ST_DRN: begin
          if (drn_r == DRN_W'(DRN_LEN - 1)) begin
            state_r <= (k_nxt == eff) ? ST_QRY : ST_PIV;
          end
        end
        ST_QRY:  state_r <= ST_RD;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // counters, item fields and result payload
  always_ff @(posedge clk) begin
    src_j_r <= j_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          row_r <= in_ch.row_index;
          col_r <= in_ch.col_index;
          cmp_r <= (in_ch.cmd == btc_pkg::CMD_COMPUTE);
          k_r   <= '0;
          out_word_r  <= '0;
          out_reach_r <= 1'b0;
          out_err_r   <= idx_err;
        end
      end
      ST_RD: begin
        out_word_r  <= rd_word;
        out_reach_r <= cmp_r && (rd_word != '0);
        out_err_r   <= 1'b0;
      end
      ST_CAP: begin
        j_r   <= '0;
        drn_r <= '0;
      end
      ST_SRC: j_r <= j_r + btc_pkg::IDX_W'(1);
      ST_DRN: begin
        drn_r <= drn_r + DRN_W'(1);
        if (drn_r == DRN_W'(DRN_LEN - 1)) begin
          k_r <= k_nxt;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_word = out_word_r;
  assign out_ch.reachable   = out_reach_r;
  assign out_ch.index_error = out_err_r;

endmodule

@@ design/btc_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the closure block, bound to the top level
// depends on btc_pkg and boolean_transitive_closure
module btc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [btc_pkg::WORD_W-1:0] result_word,
  input logic                       reachable,
  input logic                       index_error
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_word))
    else $error("result word changed while stalled");

  // reachable only with a nonzero closure word
  a_reach: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reachable |-> result_word != '0 && !index_error)
    else $error("reachable with zero word or index error");

  // flagged items carry nothing
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && index_error |-> result_word == '0 && !reachable)
    else $error("index error with payload");

  // input taken only with an empty result register
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("ready while a result is pending");

endmodule

bind boolean_transitive_closure btc_checker u_btc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_word (out_ch.result_word),
  .reachable   (out_ch.reachable),
  .index_error (out_ch.index_error)
);
